// ===== design/meps_pkg.sv =====
// shared types, constants and helpers for the mandelbrot escape-time pixel engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package meps_pkg;

    // field and port widths
    localparam int IN_W        = 12;   // column and row fields
    localparam int WORD_W      = 32;   // q4.28 coordinate word
    localparam int STEP_W      = 31;
    localparam int COUNT_W     = 16;
    localparam int COLOR_W     = 8;
    localparam int TINT_W      = 3;
    localparam int S_TDATA_W   = 2 * IN_W;
    localparam int M_TDATA_W   = 3 * COLOR_W + COUNT_W;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int SAT_IN_W    = 66;

    // parameter defaults
    localparam int DEF_COORD_BITS  = 12;
    localparam int DEF_FRAC_BITS   = 28;
    localparam int DEF_QUEUE_DEPTH = 2;

    // register map, byte address is 4 * index
    localparam logic [CFG_IDX_W-1:0] REG_REAL_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TINT      = 3'd5;

    // reset values
    localparam logic signed [WORD_W-1:0] RST_REAL_MIN  = 32'shE000_0000;
    localparam logic signed [WORD_W-1:0] RST_IMAG_MAX  = 32'sh1800_0000;
    localparam logic [STEP_W-1:0]        RST_REAL_STEP = 31'd838861;
    localparam logic [STEP_W-1:0]        RST_IMAG_STEP = 31'd1118481;
    localparam logic [COUNT_W-1:0]       RST_MAX_ITER  = 16'd25600;
    localparam logic [TINT_W-1:0]        RST_TINT      = 3'd1;

    // tint codes, any other code clears nothing
    localparam logic [TINT_W-1:0] TINT_R_OFF  = 3'd0;
    localparam logic [TINT_W-1:0] TINT_G_OFF  = 3'd1;
    localparam logic [TINT_W-1:0] TINT_B_OFF  = 3'd2;
    localparam logic [TINT_W-1:0] TINT_GB_OFF = 3'd3;
    localparam logic [TINT_W-1:0] TINT_RB_OFF = 3'd4;
    localparam logic [TINT_W-1:0] TINT_RG_OFF = 3'd5;

    localparam logic [COLOR_W-1:0] GREY_MAX = 8'd255;

    localparam logic signed [SAT_IN_W-1:0] WORD_MAX_WIDE = 66'sd2147483647;
    localparam logic signed [SAT_IN_W-1:0] WORD_MIN_WIDE = -66'sd2147483648;

    typedef struct packed {
        logic signed [WORD_W-1:0] real_min;
        logic signed [WORD_W-1:0] imag_max;
        logic [STEP_W-1:0]        real_step;
        logic [STEP_W-1:0]        imag_step;
        logic [COUNT_W-1:0]       max_iterations;
        logic [TINT_W-1:0]        tint_select;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] cx;
        logic signed [WORD_W-1:0] cy;
    } point_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_IN_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WORD_MAX_WIDE)
            r = WORD_MAX_WIDE[WORD_W-1:0];
        else if (v < WORD_MIN_WIDE)
            r = WORD_MIN_WIDE[WORD_W-1:0];
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

// ===== design/mandelbrot_escape_pixel_top.sv =====
// top level of the mandelbrot escape-time pixel engine: register file and the three parts
// depends on meps_pkg, meps_front, meps_queue, meps_back
`timescale 1ns / 1ps

//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+---------------------------------------
//  s_*      | in        | s_tvalid / s_tready            | s_tdata: column [11:0], row [23:12]
//  m_*      | out       | m_tvalid / m_tready            | m_tdata: red, green, blue, count [39:24]
//  apb      | in / out  | psel, penable, pwrite, pready  | paddr 4*index, pwdata, prdata
//
// the engine holds a pixel through a pop step, then a product step and an escape-test/update
// step per iteration, at most max_iterations of them, and for the final test, and then
// one colouring step
// reset clears handshakes, queue fill and engine state; registers load their defaults
// the front end keeps filling the queue while the engine iterates; a finished beat waits in
// the output register and the engine stalls in its colouring cycle only while that is held

module mandelbrot_escape_pixel_top #(
    parameter int COORD_BITS  = meps_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS   = meps_pkg::DEF_FRAC_BITS,
    parameter int QUEUE_DEPTH = meps_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // pixel beats in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [meps_pkg::S_TDATA_W-1:0]   s_tdata,   // column [11:0], row [23:12]
    // result beats out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [meps_pkg::M_TDATA_W-1:0]   m_tdata,   // red, green, blue, iteration_count
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [meps_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [meps_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [meps_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import meps_pkg::*;

    cfg_t                   cfg_reg;
    logic                   cfg_wr;
    logic [CFG_IDX_W-1:0]   reg_index;

    logic                   push;
    logic                   pop;
    logic                   full;
    logic                   empty;
    point_t                 front_point;
    point_t                 queue_point;

    // register file, written on the access phase of the bus
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_index = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_min       <= RST_REAL_MIN;
            cfg_reg.imag_max       <= RST_IMAG_MAX;
            cfg_reg.real_step      <= RST_REAL_STEP;
            cfg_reg.imag_step      <= RST_IMAG_STEP;
            cfg_reg.max_iterations <= RST_MAX_ITER;
            cfg_reg.tint_select    <= RST_TINT;
        end
        else if (cfg_wr)
        begin
            unique case (reg_index)
                REG_REAL_MIN:  cfg_reg.real_min       <= pwdata;
                REG_IMAG_MAX:  cfg_reg.imag_max       <= pwdata;
                REG_REAL_STEP: cfg_reg.real_step      <= pwdata[STEP_W-1:0];
                REG_IMAG_STEP: cfg_reg.imag_step      <= pwdata[STEP_W-1:0];
                REG_MAX_ITER:  cfg_reg.max_iterations <= pwdata[COUNT_W-1:0];
                REG_TINT:      cfg_reg.tint_select    <= pwdata[TINT_W-1:0];
                default:       ;   // unmapped, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_REAL_MIN:  prdata = cfg_reg.real_min;
            REG_IMAG_MAX:  prdata = cfg_reg.imag_max;
            REG_REAL_STEP: prdata = CFG_DATA_W'(cfg_reg.real_step);
            REG_IMAG_STEP: prdata = CFG_DATA_W'(cfg_reg.imag_step);
            REG_MAX_ITER:  prdata = CFG_DATA_W'(cfg_reg.max_iterations);
            REG_TINT:      prdata = CFG_DATA_W'(cfg_reg.tint_select);
            default:       prdata = '0;
        endcase
    end

    // front end: pixel beat to point c
    meps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .full     (full),
        .push     (push),
        .point    (front_point)
    );

    // decoupling queue
    meps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_point),
        .pop       (pop),
        .pop_data  (queue_point),
        .full      (full),
        .empty     (empty)
    );

    // iteration engine and output register
    meps_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .empty    (empty),
        .pop      (pop),
        .point    (queue_point),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");

    // a lit red channel always carries the clipped grey of the beat's own count
    a_grey_match: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[COLOR_W-1:0] != '0)) |->
        (m_tdata[COLOR_W-1:0] ==
            ((m_tdata[M_TDATA_W-1:3*COLOR_W] > COUNT_W'(GREY_MAX)) ?
                GREY_MAX : m_tdata[3*COLOR_W+COLOR_W-1:3*COLOR_W])))
        else $error("red channel does not match iteration count");

endmodule

// ===== design/meps_front.sv =====
// front end: accepts pixel beats, forms the point c and pushes it into the queue
// depends on meps_pkg
`timescale 1ns / 1ps

module meps_front #(
    parameter int COORD_BITS = meps_pkg::DEF_COORD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  meps_pkg::cfg_t                  cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [meps_pkg::S_TDATA_W-1:0]  s_tdata,   // column, row
    input  logic                            full,
    output logic                            push,
    output meps_pkg::point_t                point
);
    import meps_pkg::*;

    localparam int PROD_W = IN_W + STEP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [IN_W-1:0] CMASK = IN_W'((64'd1 << COORD_BITS) - 64'd1);

    logic                    hold_valid_reg;
    logic [PROD_W-1:0]       re_prod_reg;
    logic [PROD_W-1:0]       im_prod_reg;
    logic [IN_W-1:0]         column;
    logic [IN_W-1:0]         row;
    logic signed [SUM_W-1:0] re_sum;
    logic signed [SUM_W-1:0] im_sum;

    assign column   = s_tdata[IN_W-1:0] & CMASK;
    assign row      = s_tdata[2*IN_W-1:IN_W] & CMASK;
    assign push     = hold_valid_reg && !full;
    assign s_tready = !hold_valid_reg || push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (s_tready)
            hold_valid_reg <= s_tvalid;
    end

    // offsets from the image edges
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            re_prod_reg <= PROD_W'(column) * PROD_W'(cfg.real_step);
            im_prod_reg <= PROD_W'(row) * PROD_W'(cfg.imag_step);
        end
    end

    always_comb
    begin
        re_sum   = SUM_W'(cfg.real_min) + SUM_W'(re_prod_reg);
        im_sum   = SUM_W'(cfg.imag_max) - SUM_W'(im_prod_reg);
        point.cx = sat_word(SAT_IN_W'(re_sum));
        point.cy = sat_word(SAT_IN_W'(im_sum));
    end

endmodule

// ===== design/meps_queue.sv =====
// short queue of points between the front end and the iteration engine
// depends on meps_pkg
`timescale 1ns / 1ps

module meps_queue #(
    parameter int DEPTH = meps_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  meps_pkg::point_t push_data,
    input  logic             pop,
    output meps_pkg::point_t pop_data,
    output logic             full,
    output logic             empty
);
    import meps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    point_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/meps_back.sv =====
// iteration engine: runs z = z*z + c on one shared multiplier set, then colours the pixel
// depends on meps_pkg
`timescale 1ns / 1ps

module meps_back #(
    parameter int FRAC_BITS = meps_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  meps_pkg::cfg_t                  cfg,
    input  logic                            empty,
    output logic                            pop,
    input  meps_pkg::point_t                point,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [meps_pkg::M_TDATA_W-1:0]  m_tdata    // red, green, blue, iteration_count
);
    import meps_pkg::*;

    localparam int PROD_W = 2 * WORD_W;
    localparam logic [PROD_W:0] BAIL = (PROD_W + 1)'(4) << (2 * FRAC_BITS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic signed [WORD_W-1:0] x_reg;
    logic signed [WORD_W-1:0] y_reg;
    logic signed [WORD_W-1:0] cx_reg;
    logic signed [WORD_W-1:0] cy_reg;
    logic signed [PROD_W-1:0] xx_reg;
    logic signed [PROD_W-1:0] yy_reg;
    logic signed [PROD_W-1:0] xy_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;

    logic [PROD_W:0]          mag_sum;
    logic                     keep_going;
    logic signed [PROD_W-1:0] diff;
    logic signed [PROD_W-1:0] diff_sh;
    logic signed [PROD_W-1:0] xy_sh;
    logic signed [WORD_W-1:0] x_new;
    logic signed [WORD_W-1:0] y_new;
    logic                     out_load;
    logic [COLOR_W-1:0]       grey;
    logic [COLOR_W-1:0]       red;
    logic [COLOR_W-1:0]       green;
    logic [COLOR_W-1:0]       blue;

    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // escape test and update both use the products of the current z
    always_comb
    begin
        mag_sum    = {1'b0, xx_reg} + {1'b0, yy_reg};
        keep_going = (mag_sum <= BAIL) && (count_reg < cfg.max_iterations);
        diff       = xx_reg - yy_reg;
        diff_sh    = diff >>> FRAC_BITS;
        xy_sh      = xy_reg >>> (FRAC_BITS - 1);
        x_new      = sat_word(SAT_IN_W'(diff_sh) + SAT_IN_W'(cx_reg));
        y_new      = sat_word(SAT_IN_W'(xy_sh) + SAT_IN_W'(cy_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!empty) state_next = ST_MUL;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = keep_going ? ST_MUL : ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg     <= point.cx;
            y_reg     <= point.cy;
            cx_reg    <= point.cx;
            cy_reg    <= point.cy;
            count_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            xx_reg <= PROD_W'(x_reg) * PROD_W'(x_reg);
            yy_reg <= PROD_W'(y_reg) * PROD_W'(y_reg);
            xy_reg <= PROD_W'(x_reg) * PROD_W'(y_reg);
        end
        if ((state_reg == ST_UPD) && keep_going)
        begin
            x_reg     <= x_new;
            y_reg     <= y_new;
            count_reg <= count_reg + COUNT_W'(1);
        end
        if (out_load)
            out_data_reg <= {count_reg, blue, green, red};
    end

    // colour: black inside the set, else clipped grey with channels masked by tint
    always_comb
    begin
        grey  = (count_reg > COUNT_W'(GREY_MAX)) ? GREY_MAX : count_reg[COLOR_W-1:0];
        red   = grey;
        green = grey;
        blue  = grey;
        unique case (cfg.tint_select)
            TINT_R_OFF:  red = '0;
            TINT_G_OFF:  green = '0;
            TINT_B_OFF:  blue = '0;
            TINT_GB_OFF: begin green = '0; blue = '0; end
            TINT_RB_OFF: begin red = '0; blue = '0; end
            TINT_RG_OFF: begin red = '0; green = '0; end
            default:     ;
        endcase
        if (count_reg == cfg.max_iterations)
        begin
            red   = '0;
            green = '0;
            blue  = '0;
        end
    end

endmodule
